// ===== sv/mbet_pkg.sv =====
// Shared types, constants, microcode table and helpers of the escape-time unit.
package mbet_pkg;

  // Fixed-point and field widths
  localparam int unsigned QW      = 32;   // Q4.28 coordinate width
  localparam int unsigned FracW   = 28;   // fraction bits
  localparam int unsigned PixW    = 12;   // pixel index width
  localparam int unsigned DimW    = 13;   // image dimension width
  localparam int unsigned CntW    = 9;    // iteration count and cap width
  localparam int unsigned EscW    = 31;   // escape limit width
  localparam int unsigned OpW     = 33;   // multiplier operand width
  localparam int unsigned ProdW   = 66;   // full product width
  localparam int unsigned SqW     = 40;   // truncated square and cross term width
  localparam int unsigned SumW    = 48;   // width ahead of saturation
  localparam int unsigned DivW    = 45;   // dividend magnitude width
  localparam int unsigned DivCntW = 6;    // divider step counter width
  localparam int unsigned QuoW    = 46;   // signed quotient width

  // Configuration register indexes
  localparam int unsigned RegIdxW = 3;
  localparam logic [RegIdxW-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [RegIdxW-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [RegIdxW-1:0] REG_REAL_MIN     = 3'd2;
  localparam logic [RegIdxW-1:0] REG_REAL_MAX     = 3'd3;
  localparam logic [RegIdxW-1:0] REG_IMAG_MIN     = 3'd4;
  localparam logic [RegIdxW-1:0] REG_IMAG_MAX     = 3'd5;
  localparam logic [RegIdxW-1:0] REG_MAX_ITER     = 3'd6;
  localparam logic [RegIdxW-1:0] REG_ESCAPE_R2    = 3'd7;

  // Program steps
  localparam int unsigned StepW = 4;
  localparam logic [StepW-1:0] STEP_IDLE      = 4'd0;
  localparam logic [StepW-1:0] STEP_MAPR_MUL  = 4'd1;
  localparam logic [StepW-1:0] STEP_MAPR_DIV  = 4'd2;
  localparam logic [StepW-1:0] STEP_MAPR_WAIT = 4'd3;
  localparam logic [StepW-1:0] STEP_MAPR_ADD  = 4'd4;
  localparam logic [StepW-1:0] STEP_MAPI_DIV  = 4'd5;
  localparam logic [StepW-1:0] STEP_MAPI_WAIT = 4'd6;
  localparam logic [StepW-1:0] STEP_MAPI_ADD  = 4'd7;
  localparam logic [StepW-1:0] STEP_IT_SQI    = 4'd8;
  localparam logic [StepW-1:0] STEP_IT_CROSS  = 4'd9;
  localparam logic [StepW-1:0] STEP_IT_TEST   = 4'd10;
  localparam logic [StepW-1:0] STEP_IT_SQR    = 4'd11;
  localparam logic [StepW-1:0] STEP_DONE      = 4'd12;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN,
    COND_DIV,
    COND_STOP,
    COND_OUT
  } cond_e;

  // Multiplier operand selection
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_MAP_R,
    MUL_MAP_I,
    MUL_ZR_ZR,
    MUL_ZI_ZI,
    MUL_ZR_ZI
  } mul_e;

  // One control word
  typedef struct packed {
    logic [StepW-1:0] next_pc;   // target when the condition holds
    cond_e            cond;
    logic             hold;      // condition false: stay (1) or fall through (0)
    mul_e             mul_sel;
    logic             z_clr;     // clear z and count
    logic             div_start;
    logic             div_imag;  // divide by image height instead of width
    logic             cr_ld;
    logic             ci_ld;
    logic             rr_ld;
    logic             ii_ld;
    logic             iter;      // test step: advance z or stop
    logic             out_ld;
  } ucode_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic              neg;
    logic [DivW-1:0]   mag;
    logic [DimW-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                   busy;
    logic signed [QuoW-1:0] quotient;
  } div_rsp_t;

  // Build a control word
  function automatic ucode_t uw(input logic [StepW-1:0] nxt, input cond_e c,
                                input logic hld, input mul_e m);
    ucode_t w;
    w         = '0;
    w.next_pc = nxt;
    w.cond    = c;
    w.hold    = hld;
    w.mul_sel = m;
    return w;
  endfunction

  // Microcode table
  function automatic ucode_t ucode(input logic [StepW-1:0] pc);
    ucode_t w;
    w = uw(STEP_IDLE, COND_ALWAYS, 1'b0, MUL_NONE);
    unique case (pc)
      STEP_IDLE:      w = uw(STEP_MAPR_MUL, COND_IN, 1'b1, MUL_NONE);
      STEP_MAPR_MUL: begin
        w = uw(STEP_MAPR_DIV, COND_ALWAYS, 1'b0, MUL_MAP_R);
        w.z_clr = 1'b1;
      end
      STEP_MAPR_DIV: begin
        w = uw(STEP_MAPR_WAIT, COND_ALWAYS, 1'b0, MUL_NONE);
        w.div_start = 1'b1;
      end
      STEP_MAPR_WAIT: w = uw(STEP_MAPR_ADD, COND_DIV, 1'b1, MUL_NONE);
      STEP_MAPR_ADD: begin
        w = uw(STEP_MAPI_DIV, COND_ALWAYS, 1'b0, MUL_MAP_I);
        w.cr_ld = 1'b1;
      end
      STEP_MAPI_DIV: begin
        w = uw(STEP_MAPI_WAIT, COND_ALWAYS, 1'b0, MUL_NONE);
        w.div_start = 1'b1;
        w.div_imag  = 1'b1;
      end
      STEP_MAPI_WAIT: w = uw(STEP_MAPI_ADD, COND_DIV, 1'b1, MUL_NONE);
      STEP_MAPI_ADD: begin
        w = uw(STEP_IT_SQI, COND_ALWAYS, 1'b0, MUL_ZR_ZR);
        w.ci_ld = 1'b1;
      end
      STEP_IT_SQI: begin
        w = uw(STEP_IT_CROSS, COND_ALWAYS, 1'b0, MUL_ZI_ZI);
        w.rr_ld = 1'b1;
      end
      STEP_IT_CROSS: begin
        w = uw(STEP_IT_TEST, COND_ALWAYS, 1'b0, MUL_ZR_ZI);
        w.ii_ld = 1'b1;
      end
      STEP_IT_TEST: begin
        w = uw(STEP_DONE, COND_STOP, 1'b0, MUL_NONE);
        w.iter = 1'b1;
      end
      STEP_IT_SQR:    w = uw(STEP_IT_SQI, COND_ALWAYS, 1'b0, MUL_ZR_ZR);
      STEP_DONE: begin
        w = uw(STEP_IDLE, COND_OUT, 1'b1, MUL_NONE);
        w.out_ld = 1'b1;
      end
      default:        w = uw(STEP_IDLE, COND_ALWAYS, 1'b0, MUL_NONE);
    endcase
    return w;
  endfunction

  // Clamp to the signed Q4.28 range
  function automatic logic signed [QW-1:0] sat_q(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(64'sh7FFF_FFFF);
    lo = -hi - SumW'(1);
    if (v > hi) begin
      return hi[QW-1:0];
    end else if (v < lo) begin
      return lo[QW-1:0];
    end
    return v[QW-1:0];
  endfunction

endpackage

// ===== sv/mbet_divider.sv =====
// Restoring divider, one quotient bit per cycle, signed result.
module mbet_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mbet_pkg::div_req_t req_i,
  output mbet_pkg::div_rsp_t rsp_o
);

  logic                         busy_q, busy_d;
  logic [mbet_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                         neg_q, neg_d;
  logic [mbet_pkg::DimW-1:0]    den_q, den_d;
  logic [mbet_pkg::DimW-1:0]    rem_q, rem_d;
  logic [mbet_pkg::DivW-1:0]    quo_q, quo_d;
  logic [mbet_pkg::DimW:0]      trial;
  logic [mbet_pkg::DimW:0]      diff;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, quo_q[mbet_pkg::DivW-1]};
  assign diff  = trial - {1'b0, den_q};

  // Step control
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = mbet_pkg::DivCntW'(mbet_pkg::DivW - 1);
      neg_d  = req_i.neg;
      den_d  = (req_i.divisor == '0) ? mbet_pkg::DimW'(1) : req_i.divisor;
      rem_d  = '0;
      quo_d  = req_i.mag;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[mbet_pkg::DimW-1:0];
        quo_d = {quo_q[mbet_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_d = trial[mbet_pkg::DimW-1:0];
        quo_d = {quo_q[mbet_pkg::DivW-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // Apply the sign, truncating toward zero
  assign rsp_o.busy     = busy_q;
  assign rsp_o.quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

// ===== sv/mandelbrot_escape_time_unit.sv =====
// Top level of the escape-time unit: config registers, microcode sequencer, datapath.
//
// Channel   Direction  Beat contents
// s_axis    in         tdata[11:0] pixel_x, tdata[23:12] pixel_y
// m_axis    out        tdata[8:0] iteration_count, tdata[9] reached_cap
// cfg       in         cfg_index_i register index, cfg_data_i value
//
// One pixel at a time. Each of the two axis mappings holds in a wait step on
// the bit-serial divider. Each escape iteration takes four steps through the
// single shared 33x33 multiplier, and the final test, the done step and the
// idle step follow the last iteration. Reset returns the configuration
// registers to their defaults and the program to the idle step. A new pixel
// is taken while a result still waits; the finished next result holds in the
// done step until the output register is free.
module mandelbrot_escape_time_unit #(
  parameter int unsigned MAX_ITER = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,   // pixel_x, pixel_y
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,   // iteration_count, reached_cap, zeros
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mbet_pkg::RegIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  localparam int unsigned CW = mbet_pkg::CntW;

  // Configuration registers
  logic        [mbet_pkg::DimW-1:0] width_q, height_q;
  logic signed [mbet_pkg::QW-1:0]   real_min_q, real_max_q, imag_min_q, imag_max_q;
  logic        [CW-1:0]             max_iter_q;
  logic        [mbet_pkg::EscW-1:0] esc_q;

  // Sequencer
  logic [mbet_pkg::StepW-1:0] pc_q, pc_d;
  mbet_pkg::ucode_t           cw;
  logic                       met;

  // Datapath
  logic        [mbet_pkg::PixW-1:0]  px_q, py_q;
  logic signed [mbet_pkg::OpW-1:0]   op_a, op_b;
  logic signed [mbet_pkg::ProdW-1:0] p_q, p_d;
  logic signed [mbet_pkg::QW-1:0]    cr_q, ci_q, zr_q, zi_q;
  logic signed [mbet_pkg::SqW-1:0]   rr_q, ii_q, ri;
  logic        [mbet_pkg::SqW-1:0]   mag2;
  logic        [CW-1:0]              count_q, cap_eff;
  logic                              at_cap, escaped, stop, capped_q;
  logic                              out_valid_q, out_free;
  logic        [CW-1:0]              out_count_q;
  logic                              out_capped_q;
  logic signed [mbet_pkg::QW-1:0]    map_lo;
  mbet_pkg::div_req_t                div_req;
  mbet_pkg::div_rsp_t                div_rsp;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= mbet_pkg::DimW'(640);
      height_q   <= mbet_pkg::DimW'(480);
      real_min_q <= -32'sd536870912;
      real_max_q <= 32'sd268435456;
      imag_min_q <= -32'sd402653184;
      imag_max_q <= 32'sd402653184;
      max_iter_q <= CW'(256);
      esc_q      <= mbet_pkg::EscW'(1073741824);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mbet_pkg::REG_IMAGE_WIDTH:  width_q    <= cfg_data_i[mbet_pkg::DimW-1:0];
        mbet_pkg::REG_IMAGE_HEIGHT: height_q   <= cfg_data_i[mbet_pkg::DimW-1:0];
        mbet_pkg::REG_REAL_MIN:     real_min_q <= cfg_data_i;
        mbet_pkg::REG_REAL_MAX:     real_max_q <= cfg_data_i;
        mbet_pkg::REG_IMAG_MIN:     imag_min_q <= cfg_data_i;
        mbet_pkg::REG_IMAG_MAX:     imag_max_q <= cfg_data_i;
        mbet_pkg::REG_MAX_ITER:     max_iter_q <= cfg_data_i[CW-1:0];
        mbet_pkg::REG_ESCAPE_R2:    esc_q      <= cfg_data_i[mbet_pkg::EscW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the cap to the build limit
  assign cap_eff = (32'(max_iter_q) > MAX_ITER) ? CW'(MAX_ITER) : max_iter_q;

  // Loop tests
  assign mag2    = mbet_pkg::SqW'(rr_q + ii_q);
  assign at_cap  = (count_q == cap_eff);
  assign escaped = (mag2 >= {{(mbet_pkg::SqW - mbet_pkg::EscW){1'b0}}, esc_q});
  assign stop    = at_cap || escaped;

  assign out_free = !out_valid_q || m_axis_tready;

  // Fetch the control word and resolve the jump
  always_comb begin
    cw = mbet_pkg::ucode(pc_q);
    met = 1'b0;
    unique case (cw.cond)
      mbet_pkg::COND_ALWAYS: met = 1'b1;
      mbet_pkg::COND_IN:     met = s_axis_tvalid;
      mbet_pkg::COND_DIV:    met = !div_rsp.busy;
      mbet_pkg::COND_STOP:   met = stop;
      mbet_pkg::COND_OUT:    met = out_free;
      default:               met = 1'b1;
    endcase
    if (met) begin
      pc_d = cw.next_pc;
    end else if (cw.hold) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  assign s_axis_tready = (cw.cond == mbet_pkg::COND_IN);

  // Select multiplier operands
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cw.mul_sel)
      mbet_pkg::MUL_NONE: ;
      mbet_pkg::MUL_MAP_R: begin
        op_a = mbet_pkg::OpW'(real_max_q) - mbet_pkg::OpW'(real_min_q);
        op_b = $signed({{(mbet_pkg::OpW - mbet_pkg::PixW){1'b0}}, px_q});
      end
      mbet_pkg::MUL_MAP_I: begin
        op_a = mbet_pkg::OpW'(imag_min_q) - mbet_pkg::OpW'(imag_max_q);
        op_b = $signed({{(mbet_pkg::OpW - mbet_pkg::PixW){1'b0}}, py_q});
      end
      mbet_pkg::MUL_ZR_ZR: begin
        op_a = mbet_pkg::OpW'(zr_q);
        op_b = mbet_pkg::OpW'(zr_q);
      end
      mbet_pkg::MUL_ZI_ZI: begin
        op_a = mbet_pkg::OpW'(zi_q);
        op_b = mbet_pkg::OpW'(zi_q);
      end
      mbet_pkg::MUL_ZR_ZI: begin
        op_a = mbet_pkg::OpW'(zr_q);
        op_b = mbet_pkg::OpW'(zi_q);
      end
      default: ;
    endcase
  end

  assign p_d = op_a * op_b;

  // Divider request from the registered mapping product
  assign div_req.start   = cw.div_start;
  assign div_req.neg     = p_q[mbet_pkg::ProdW-1];
  assign div_req.mag     = p_q[mbet_pkg::ProdW-1] ? mbet_pkg::DivW'(-p_q)
                                                  : mbet_pkg::DivW'(p_q);
  assign div_req.divisor = cw.div_imag ? height_q : width_q;

  mbet_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign map_lo = cw.ci_ld ? imag_max_q : real_min_q;
  assign ri     = mbet_pkg::SqW'(p_q >>> (mbet_pkg::FracW - 1));

  // Advance the sequencer and the output slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= mbet_pkg::STEP_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (cw.out_ld && met) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      px_q <= s_axis_tdata[mbet_pkg::PixW-1:0];
      py_q <= s_axis_tdata[2*mbet_pkg::PixW-1:mbet_pkg::PixW];
    end
    if (cw.mul_sel != mbet_pkg::MUL_NONE) begin
      p_q <= p_d;
    end
    if (cw.cr_ld || cw.ci_ld) begin
      if (cw.cr_ld) begin
        cr_q <= mbet_pkg::sat_q(mbet_pkg::SumW'(map_lo) + mbet_pkg::SumW'(div_rsp.quotient));
      end else begin
        ci_q <= mbet_pkg::sat_q(mbet_pkg::SumW'(map_lo) + mbet_pkg::SumW'(div_rsp.quotient));
      end
    end
    if (cw.rr_ld) begin
      rr_q <= mbet_pkg::SqW'(p_q >>> mbet_pkg::FracW);
    end
    if (cw.ii_ld) begin
      ii_q <= mbet_pkg::SqW'(p_q >>> mbet_pkg::FracW);
    end
    if (cw.z_clr) begin
      zr_q    <= '0;
      zi_q    <= '0;
      count_q <= '0;
    end else if (cw.iter) begin
      capped_q <= at_cap;
      if (!stop) begin
        zr_q    <= mbet_pkg::sat_q(mbet_pkg::SumW'(rr_q) - mbet_pkg::SumW'(ii_q)
                                   + mbet_pkg::SumW'(cr_q));
        zi_q    <= mbet_pkg::sat_q(mbet_pkg::SumW'(ri) + mbet_pkg::SumW'(ci_q));
        count_q <= count_q + 1'b1;
      end
    end
    if (cw.out_ld && met) begin
      out_count_q  <= count_q;
      out_capped_q <= capped_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(16 - CW - 1){1'b0}}, out_capped_q, out_count_q};

  // Checks
  a_div_busy_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> (pc_q == mbet_pkg::STEP_MAPR_WAIT || pc_q == mbet_pkg::STEP_MAPI_WAIT))
    else $error("divider busy outside a wait step");

  a_count_within_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == mbet_pkg::STEP_IT_TEST) |-> (count_q <= cap_eff))
    else $error("iteration count passed the cap");

  a_accept_starts_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (pc_q == mbet_pkg::STEP_MAPR_MUL))
    else $error("accepted pixel did not start the mapping");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == mbet_pkg::STEP_DONE && out_valid_q && !m_axis_tready)
      |=> (pc_q == mbet_pkg::STEP_DONE))
    else $error("result left the done step while the output was occupied");

endmodule
